### sv/keyed_device_cache_oldest_evict_defines.svh
// assertion macros used by the cache datapath
`ifndef KEYED_DEVICE_CACHE_OLDEST_EVICT_DEFINES_SVH
`define KEYED_DEVICE_CACHE_OLDEST_EVICT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define KDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define KDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/kdc_pkg.sv
// types, codes and sizes of the device cache
package kdc_pkg;

  localparam int CACHE_ENTRIES = 10;
  localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);

  localparam int OP_W    = 2;
  localparam int MAC_W   = 48;
  localparam int TIME_W  = 48;
  localparam int PAY_W   = 32;
  localparam int POS_W   = 4;
  localparam int SLOTO_W = 4;
  localparam int KIND_W  = 2;
  localparam int LIVE_W  = 5;
  localparam int LIMIT_W = 32;

  localparam logic [LIMIT_W-1:0] STALE_RESET = LIMIT_W'(60000);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_PRUNE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [MAC_W-1:0]  device_mac;
    logic [TIME_W-1:0] seen_time_ms;
    logic [PAY_W-1:0]  record_payload;
    logic [TIME_W-1:0] current_time_ms;
    logic [POS_W-1:0]  live_position;
  } kdc_item_t;

  typedef struct packed {
    logic [SLOTO_W-1:0] slot_used;
    logic [KIND_W-1:0]  insert_kind;
    logic [LIVE_W-1:0]  live_entries;
    logic               entry_found;
    logic [MAC_W-1:0]   entry_mac;
    logic [TIME_W-1:0]  entry_time_ms;
    logic [PAY_W-1:0]   entry_payload;
  } kdc_result_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } kdc_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } kdc_sts_t;

endpackage

### sv/kdc_if.sv
// request and response channel interfaces
interface kdc_in_if;
  import kdc_pkg::*;
  logic      valid;
  logic      ready;
  kdc_item_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface kdc_out_if;
  import kdc_pkg::*;
  logic        valid;
  logic        ready;
  kdc_result_t word;
  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

### sv/kdc_ctrl.sv
// controller state machine: accept, scan, commit
module kdc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kdc_pkg::kdc_sts_t sts,
  output kdc_pkg::kdc_cmd_t cmd
);
  import kdc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### sv/kdc_dp.sv
// datapath: slot storage, entry scan, output register
module kdc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kdc_pkg::kdc_cmd_t             cmd,
  output kdc_pkg::kdc_sts_t             sts,
  input  kdc_pkg::kdc_item_t            in_word,
  output kdc_pkg::kdc_result_t          out_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          cfg_we,
  input  logic [kdc_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import kdc_pkg::*;
  `include "keyed_device_cache_oldest_evict_defines.svh"

  logic [CACHE_ENTRIES-1:0] occ;
  logic [MAC_W-1:0]         mac_mem  [CACHE_ENTRIES];
  logic [TIME_W-1:0]        time_mem [CACHE_ENTRIES];
  logic [PAY_W-1:0]         pay_mem  [CACHE_ENTRIES];
  logic [LIVE_W-1:0]        live_count;
  logic [LIMIT_W-1:0]       stale_limit;

  kdc_item_t         cur;
  logic [SLOT_W-1:0] idx;
  logic              hit_v, emp_v, old_v, found;
  logic [SLOT_W-1:0] hit_idx, emp_idx, old_idx, rd_slot;
  logic [TIME_W-1:0] old_t;
  logic [CNT_W-1:0]  cnt, seen;
  logic [MAC_W-1:0]  rd_mac;
  logic [TIME_W-1:0] rd_time;
  logic [PAY_W-1:0]  rd_pay;

  logic              occ_e, match_e, older_e, stale_e, pos_e, stop_e;
  logic [MAC_W-1:0]  mac_e;
  logic [TIME_W-1:0] t_e;
  logic [SLOT_W-1:0] sel;
  logic [KIND_W-1:0] kind;
  kdc_result_t       res;

  // entry under the scan pointer
  assign occ_e   = occ[idx];
  assign mac_e   = mac_mem[idx];
  assign t_e     = time_mem[idx];
  assign match_e = (mac_e == cur.device_mac);
  assign older_e = !old_v || (t_e < old_t);
  assign stale_e = (cur.current_time_ms > t_e) &&
                   ((cur.current_time_ms - t_e) > TIME_W'(stale_limit));
  assign pos_e   = (LIVE_W'(seen) == LIVE_W'(cur.live_position));
  assign stop_e  = occ_e && (((cur.operation == OP_INSERT) && match_e) ||
                             ((cur.operation == OP_READ) && pos_e));

  assign sts.last     = (idx == SLOT_W'(CACHE_ENTRIES - 1)) || stop_e ||
                        (cur.operation == OP_NONE);
  assign sts.out_free = !out_valid || out_ready;

  // insert target
  always_comb begin
    if (hit_v) begin
      sel  = hit_idx;
      kind = KIND_UPDATE;
    end else if (emp_v) begin
      sel  = emp_idx;
      kind = KIND_FILL;
    end else if (old_v) begin
      sel  = old_idx;
      kind = KIND_EVICT;
    end else begin
      sel  = '0;
      kind = KIND_EVICT;
    end
  end

  always_comb begin
    res              = '0;
    res.live_entries = live_count;
    case (cur.operation)
      OP_INSERT: begin
        res.slot_used   = SLOTO_W'(sel);
        res.insert_kind = kind;
      end
      OP_PRUNE: res.live_entries = LIVE_W'(cnt);
      OP_READ: begin
        if (found) begin
          res.slot_used     = SLOTO_W'(rd_slot);
          res.entry_found   = 1'b1;
          res.entry_mac     = rd_mac;
          res.entry_time_ms = rd_time;
          res.entry_payload = rd_pay;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      live_count  <= '0;
      stale_limit <= STALE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) stale_limit <= cfg_wdata;
      if (cmd.step && (cur.operation == OP_PRUNE) && occ_e && stale_e) occ[idx] <= 1'b0;
      if (cmd.commit && (cur.operation == OP_INSERT)) occ[sel] <= 1'b1;
      if (cmd.commit && (cur.operation == OP_PRUNE)) live_count <= LIVE_W'(cnt);
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (cur.operation == OP_INSERT)) begin
      mac_mem[sel]  <= cur.device_mac;
      time_mem[sel] <= cur.seen_time_ms;
      pay_mem[sel]  <= cur.record_payload;
    end
    if (cmd.commit) out_word <= res;
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= in_word;
      idx   <= '0;
      hit_v <= 1'b0;
      emp_v <= 1'b0;
      old_v <= 1'b0;
      found <= 1'b0;
      cnt   <= '0;
      seen  <= '0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
      case (cur.operation)
        OP_INSERT: begin
          if (occ_e) begin
            if (match_e) begin
              hit_v   <= 1'b1;
              hit_idx <= idx;
            end else if (older_e) begin
              old_v   <= 1'b1;
              old_idx <= idx;
              old_t   <= t_e;
            end
          end else if (!emp_v) begin
            emp_v   <= 1'b1;
            emp_idx <= idx;
          end
        end
        OP_PRUNE: begin
          if (occ_e && !stale_e) cnt <= cnt + 1'b1;
        end
        OP_READ: begin
          if (occ_e) begin
            if (pos_e) begin
              found   <= 1'b1;
              rd_slot <= idx;
              rd_mac  <= mac_e;
              rd_time <= t_e;
              rd_pay  <= pay_mem[idx];
            end
            seen <= seen + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  `KDC_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid, "commit without output word")
  `KDC_ASSERT_SAME(a_read_hit_occupied, cmd.commit && (cur.operation == OP_READ) && found, occ[rd_slot], "read returned a free slot")
  `KDC_ASSERT_NEXT(a_live_count_prune_only, !(cmd.commit && (cur.operation == OP_PRUNE)), $stable(live_count), "live count moved outside prune")

endmodule

### sv/keyed_device_cache_oldest_evict.sv
// top level of the keyed device cache
// Fully associative table of CACHE_ENTRIES device records keyed by MAC. Each
// accepted word is handled alone: the datapath walks the slot registers one
// entry per cycle, stopping early on a matching MAC (insert) or on the
// requested live position (read), then, once the response register is free,
// commits the slot write or live count and loads the response register. The
// next request is accepted only after that commit. A finished response may
// sit in its register while the next request is accepted and scanned.
// stale_limit is written on any cycle with cfg_we high, so write it only
// while no word is in flight.
module keyed_device_cache_oldest_evict (
  input  logic                        clk,
  input  logic                        rst,
  kdc_in_if.sink                      req,
  kdc_out_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [kdc_pkg::LIMIT_W-1:0] cfg_wdata
);
  import kdc_pkg::*;

  kdc_cmd_t cmd;
  kdc_sts_t sts;

  kdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kdc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (req.word),
    .out_word  (rsp.word),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

### test/keyed_device_cache_oldest_evict_tb.sv
// self-checking testbench for the keyed device cache with oldest-entry eviction
module keyed_device_cache_oldest_evict_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = CACHE_ENTRIES + 4;

  class cache_scoreboard;
    logic [LIMIT_W-1:0] stale_limit;
    bit                 dev_valid [CACHE_ENTRIES];
    logic [MAC_W-1:0]   dev_mac [CACHE_ENTRIES];
    logic [TIME_W-1:0]  dev_seen [CACHE_ENTRIES];
    logic [PAY_W-1:0]   dev_payload [CACHE_ENTRIES];
    logic [LIVE_W-1:0]  live_count;
    kdc_result_t        pending [$];
    int mismatches, responses, updates, fills, evictions, prunes, reads, reads_found, unused_ops;

    function new();
      stale_limit = STALE_RESET;
      live_count = '0;
      foreach (dev_valid[i]) begin
        dev_valid[i] = 1'b0;
        dev_mac[i] = '0;
        dev_seen[i] = '0;
        dev_payload[i] = '0;
      end
    endfunction

    function void note_request(kdc_item_t it);
      kdc_result_t r;
      int hit, free_slot, oldest, pos_count, n;
      logic [TIME_W-1:0] oldest_t;
      r = '0;
      hit = -1;
      free_slot = -1;
      oldest = -1;
      oldest_t = '0;
      pos_count = 0;
      n = 0;
      case (it.operation)
        OP_INSERT: begin
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (dev_valid[i]) begin
              if (dev_mac[i] == it.device_mac) begin
                hit = i;
                break;
              end
              if (oldest < 0 || dev_seen[i] < oldest_t) begin
                oldest = i;
                oldest_t = dev_seen[i];
              end
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          if (hit >= 0) begin
            r.insert_kind = KIND_UPDATE;
            updates++;
          end else if (free_slot >= 0) begin
            hit = free_slot;
            r.insert_kind = KIND_FILL;
            fills++;
          end else begin
            hit = oldest;
            r.insert_kind = KIND_EVICT;
            evictions++;
          end
          dev_valid[hit] = 1'b1;
          dev_mac[hit] = it.device_mac;
          dev_seen[hit] = it.seen_time_ms;
          dev_payload[hit] = it.record_payload;
          r.slot_used = SLOTO_W'(hit);
        end
        OP_PRUNE: begin
          prunes++;
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (dev_valid[i]) begin
              // entries stamped in the future never age out
              if (it.current_time_ms > dev_seen[i] &&
                  (it.current_time_ms - dev_seen[i]) > TIME_W'(stale_limit))
                dev_valid[i] = 1'b0;
              else
                n++;
            end
          end
          live_count = LIVE_W'(n);
        end
        OP_READ: begin
          reads++;
          for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (dev_valid[i]) begin
              if (pos_count == it.live_position) begin
                hit = i;
                break;
              end
              pos_count++;
            end
          end
          if (hit >= 0) begin
            reads_found++;
            r.slot_used = SLOTO_W'(hit);
            r.entry_found = 1'b1;
            r.entry_mac = dev_mac[hit];
            r.entry_time_ms = dev_seen[hit];
            r.entry_payload = dev_payload[hit];
          end
        end
        default: unused_ops++;
      endcase
      r.live_entries = live_count;
      pending.push_back(r);
    endfunction

    function void check_response(kdc_result_t got);
      kdc_result_t want;
      responses++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response word %0d arrived with nothing outstanding: slot=%0d live=%0d",
                   responses, got.slot_used, got.live_entries);
        return;
      end
      want = pending.pop_front();
      if (got.slot_used !== want.slot_used || got.insert_kind !== want.insert_kind ||
          got.live_entries !== want.live_entries || got.entry_found !== want.entry_found ||
          got.entry_mac !== want.entry_mac || got.entry_time_ms !== want.entry_time_ms ||
          got.entry_payload !== want.entry_payload) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on response word %0d at %0t", responses, $realtime);
          $display("  expected slot=%0d kind=%0d live=%0d found=%0b mac=%h time=%h pay=%h",
                   want.slot_used, want.insert_kind, want.live_entries, want.entry_found,
                   want.entry_mac, want.entry_time_ms, want.entry_payload);
          $display("  actual   slot=%0d kind=%0d live=%0d found=%0b mac=%h time=%h pay=%h",
                   got.slot_used, got.insert_kind, got.live_entries, got.entry_found,
                   got.entry_mac, got.entry_time_ms, got.entry_payload);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  kdc_in_if  req_if ();
  kdc_out_if rsp_if ();

  keyed_device_cache_oldest_evict DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cache_scoreboard sb;
  bit no_idle;
  int ready_hold;
  int unsigned cycles;
  logic [MAC_W-1:0]  mac_pool [14];
  logic [TIME_W-1:0] clock_ms;
  int unsigned prune_advance;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d words outstanding",
               cycles, sb.pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // word accepted on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.word);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.word);
    end
  end

  // response back-pressure in random bursts
  always @(negedge clk) begin
    if (rst || no_idle) begin
      rsp_if.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      rsp_if.ready <= 1'b0;
      ready_hold <= $urandom_range(0, 13);
    end else begin
      rsp_if.ready <= 1'b1;
      ready_hold <= $urandom_range(0, 24);
    end
  end

  function automatic kdc_item_t make_item(logic [OP_W-1:0] op, logic [MAC_W-1:0] mac,
                                          logic [TIME_W-1:0] seen, logic [PAY_W-1:0] pay,
                                          logic [TIME_W-1:0] now, logic [POS_W-1:0] pos);
    kdc_item_t it;
    it.operation = op;
    it.device_mac = mac;
    it.seen_time_ms = seen;
    it.record_payload = pay;
    it.current_time_ms = now;
    it.live_position = pos;
    return it;
  endfunction

  function automatic kdc_item_t random_item();
    kdc_item_t it;
    int pick;
    it.operation = OP_NONE;
    it.device_mac = MAC_W'({$urandom, $urandom});
    it.seen_time_ms = TIME_W'({$urandom, $urandom});
    it.record_payload = $urandom;
    it.current_time_ms = TIME_W'({$urandom, $urandom});
    it.live_position = POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      it.operation = OP_INSERT;
      if ($urandom_range(0, 9) != 0)
        it.device_mac = mac_pool[$urandom_range(0, 13)];
      clock_ms = clock_ms + $urandom_range(0, 3000);
      case ($urandom_range(0, 9))
        0: ;
        1: it.seen_time_ms = clock_ms + $urandom_range(1, 100000);
        default: it.seen_time_ms = clock_ms - $urandom_range(0, 2000);
      endcase
    end else if (pick < 70) begin
      it.operation = OP_PRUNE;
      case ($urandom_range(0, 19))
        0: clock_ms = TIME_W'({$urandom, $urandom});
        1: clock_ms = clock_ms + 48'h1_0000_0000 + $urandom;
        default: clock_ms = clock_ms + $urandom_range(0, prune_advance);
      endcase
      it.current_time_ms = clock_ms;
    end else if (pick < 95) begin
      it.operation = OP_READ;
      if ($urandom_range(0, 3) != 0)
        it.live_position = POS_W'($urandom_range(0, CACHE_ENTRIES + 1));
    end
    return it;
  endfunction

  task automatic send_item(input kdc_item_t it);
    req_if.valid <= 1'b1;
    req_if.word <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_with_gap(input kdc_item_t it);
    send_item(it);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic write_stale_limit(input logic [LIMIT_W-1:0] value);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.stale_limit = value;
  endtask

  task automatic run_random_phase(input int count);
    for (int n = 0; n < count; n++)
      send_with_gap(random_item());
    req_if.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_with_gap(make_item(OP_READ, '0, '0, '0, '0, '0));
    send_with_gap(make_item(OP_NONE, '1, '1, '1, '1, '1));
    send_with_gap(make_item(OP_INSERT, '1, '1, '1, '0, '0));
    send_with_gap(make_item(OP_INSERT, '0, '0, '0, '1, '1));
    // two of these share the oldest stamp after slot 1 goes
    for (int k = 0; k < 8; k++)
      send_with_gap(make_item(OP_INSERT, MAC_W'(16 + k),
                              TIME_W'((k < 2) ? 100 : 100 * (k + 1)), $urandom, '0, '0));
    send_with_gap(make_item(OP_INSERT, 48'hABC, 48'd1000, $urandom, '0, '0));
    send_with_gap(make_item(OP_INSERT, 48'hABD, 48'd1001, $urandom, '0, '0));
    send_with_gap(make_item(OP_PRUNE, '0, '0, '0, '0, '0));
    send_with_gap(make_item(OP_READ, '0, '0, '0, '0, 4'd9));
    send_with_gap(make_item(OP_READ, '0, '0, '0, '0, 4'd10));
    send_with_gap(make_item(OP_READ, '0, '0, '0, '0, 4'd15));
    // age exactly at the limit stays, one more millisecond goes
    send_with_gap(make_item(OP_PRUNE, '0, '0, '0, 48'd61000, '0));
    send_with_gap(make_item(OP_PRUNE, '0, '0, '0, 48'd61001, '0));
    send_with_gap(make_item(OP_INSERT, 48'hABD, 48'd2000, $urandom, '0, '0));
    send_with_gap(make_item(OP_READ, '0, '0, '0, '0, 4'd1));
    send_with_gap(make_item(OP_INSERT, 48'hABE, 48'd2001, $urandom, '0, '0));
    send_with_gap(make_item(OP_READ, '0, '0, '0, '0, 4'd2));
    req_if.valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.word = '0;
    no_idle = 1'b0;
    clock_ms = TIME_W'($urandom_range(0, 100000));
    prune_advance = 150000;
    foreach (mac_pool[i])
      mac_pool[i] = MAC_W'({$urandom, $urandom});
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    write_stale_limit('0);
    prune_advance = 40;
    run_random_phase(350);

    write_stale_limit('1);
    prune_advance = 200000;
    run_random_phase(350);

    write_stale_limit(LIMIT_W'($urandom_range(1, 5000)));
    prune_advance = 3 * sb.stale_limit;
    run_random_phase(350);

    write_stale_limit(STALE_RESET);
    prune_advance = 150000;
    run_random_phase(350);

    write_stale_limit(LIMIT_W'(1));
    prune_advance = 4;
    no_idle = 1'b1;
    run_random_phase(400);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("checked %0d responses: %0d updates, %0d fills, %0d evictions, %0d prunes",
             sb.responses, sb.updates, sb.fills, sb.evictions, sb.prunes);
    $display("reads %0d (%0d hit a live entry), unused ops %0d, mismatches %0d",
             sb.reads, sb.reads_found, sb.unused_ops, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/kdc_pkg.sv
sv/kdc_if.sv
sv/kdc_ctrl.sv
sv/kdc_dp.sv
sv/keyed_device_cache_oldest_evict.sv
test/keyed_device_cache_oldest_evict_tb.sv
